/* rtl/pirqc_pkg.sv */
package pirqc_pkg;

	// Item kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CLOCK = 1'b1;

	// IRQ register numbers
	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_CONTROL   = 3'd1;
	localparam logic [2:0] REG_DISABLE   = 3'd2;
	localparam logic [2:0] REG_ENABLE_KP = 3'd3;
	localparam logic [2:0] REG_PRESCALER = 3'd4;
	localparam logic [2:0] REG_COUNT     = 3'd5;
	localparam logic [2:0] REG_FLIP      = 3'd6;
	localparam logic [2:0] REG_NONE      = 3'd7;

	// Prescaler masks and control bits
	localparam logic [7:0] NARROW_MASK = 8'h07;
	localparam logic [7:0] WIDE_MASK   = 8'hff;
	localparam logic [7:0] NARROW_KEEP = 8'hf8;
	localparam int         DOWN_BIT    = 7;
	localparam int         UP_BIT      = 6;
	localparam int         NARROW_BIT  = 2;

	typedef struct packed {
		logic       action;
		logic [2:0] reg_index;
		logic [7:0] data_byte;
		logic [1:0] clock_source;
		logic       blanked;
	} item_t;

	typedef struct packed {
		logic       irq_asserted;
		logic [7:0] counter_value;
		logic [7:0] prescaler_value;
	} result_t;

	typedef struct packed {
		logic       irq_enable;
		logic [1:0] source_mode;
		logic       narrow_prescale;
		logic       count_down;
		logic       count_up;
		logic [7:0] prescaler;
		logic [7:0] main_count;
		logic [7:0] flip_byte;
		logic       irq_line;
	} state_t;

endpackage

/* rtl/pirqc_if.sv */
interface pirqc_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [2:0] reg_index;
	logic [7:0] data_byte;
	logic [1:0] clock_source;
	logic       blanked;

	modport source (output valid, action, reg_index, data_byte, clock_source, blanked,
		input ready);
	modport sink (input valid, action, reg_index, data_byte, clock_source, blanked,
		output ready);
endinterface

interface pirqc_result_if;
	logic       valid;
	logic       ready;
	logic       irq_asserted;
	logic [7:0] counter_value;
	logic [7:0] prescaler_value;

	modport source (output valid, irq_asserted, counter_value, prescaler_value,
		input ready);
	modport sink (input valid, irq_asserted, counter_value, prescaler_value,
		output ready);
endinterface

/* rtl/pirqc_state.sv */
module pirqc_state (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  pirqc_pkg::item_t  item,
	output pirqc_pkg::state_t cur,
	output pirqc_pkg::state_t nxt
);
	import pirqc_pkg::*;

	state_t     st_q;
	logic       up;
	logic       hit;
	logic [7:0] mask;
	logic [7:0] low;
	logic [7:0] step;
	logic       wrap;
	logic       fire;

	assign cur = st_q;

	// Prescaler step, 8-bit or 3-bit in the low bits
	always_comb begin
		up   = st_q.count_up;
		hit  = (item.action == ACT_CLOCK) && (item.clock_source == st_q.source_mode)
			&& (st_q.count_up != st_q.count_down);
		mask = st_q.narrow_prescale ? NARROW_MASK : WIDE_MASK;
		low  = st_q.prescaler & mask;
		wrap = up ? (low == mask) : (low == 8'd0);
		step = up ? (low + 8'd1) : (low + mask);
		fire = up ? (st_q.main_count == 8'hff) : (st_q.main_count == 8'd0);
	end

	always_comb begin
		nxt = st_q;
		if (item.action == ACT_CLOCK) begin
			if (hit) begin
				nxt.prescaler = (st_q.prescaler & ~mask) | (step & mask);
				if (wrap) begin
					nxt.main_count = up ? (st_q.main_count + 8'd1) : (st_q.main_count - 8'd1);
					if (fire && st_q.irq_enable && !item.blanked)
						nxt.irq_line = 1'b1;
				end
			end
		end else begin
			case (item.reg_index)
				REG_ENABLE: begin
					nxt.irq_enable = item.data_byte[0];
					if (!item.data_byte[0])
						nxt.irq_line = 1'b0;
				end
				REG_CONTROL: begin
					nxt.source_mode     = item.data_byte[1:0];
					nxt.narrow_prescale = item.data_byte[NARROW_BIT];
					nxt.count_down      = item.data_byte[DOWN_BIT];
					nxt.count_up        = item.data_byte[UP_BIT];
				end
				REG_DISABLE: begin
					nxt.irq_enable = 1'b0;
					nxt.irq_line   = 1'b0;
				end
				REG_ENABLE_KP: nxt.irq_enable = 1'b1;
				REG_PRESCALER: nxt.prescaler  = item.data_byte ^ st_q.flip_byte;
				REG_COUNT:     nxt.main_count = item.data_byte ^ st_q.flip_byte;
				REG_FLIP:      nxt.flip_byte  = item.data_byte;
				REG_NONE:      nxt = st_q;
				default:       nxt = st_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= nxt;
		end
	end

	// Line rises only on a counting event with interrupts enabled
	a_irq_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.irq_line) |-> $past(en && item.action == ACT_CLOCK && st_q.irq_enable))
		else $error("irq line rose without an enabled clock event");

	// Narrow prescaler keeps its upper bits across clock events
	a_narrow_keep: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.action == ACT_CLOCK && st_q.narrow_prescale
		|=> (st_q.prescaler & NARROW_KEEP) == ($past(st_q.prescaler) & NARROW_KEEP))
		else $error("narrow prescaler disturbed its upper bits");

endmodule

/* rtl/prescaled_irq_counter_core.sv */
// Channel | Dir | Payload                                            | Transfer when
// item    | in  | action, reg_index, data_byte, clock_source, blanked | valid && ready
// result  | out | irq_asserted, counter_value, prescaler_value        | valid && ready
//
// One item per cycle while result.ready holds; each item passes stage 1, then stage 2.
// Stage 1 holds the item; the state update and result are one pass of logic into stage 2.
// Reset (arst_n low) clears the counter state, the line and both stage valids.
// A stalled result holds stage 2; stage 1 then holds and item.ready drops once it is full.
module prescaled_irq_counter_core (
	input logic           clk,
	input logic           arst_n,
	pirqc_item_if.sink    item,
	pirqc_result_if.source result
);
	import pirqc_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;
	state_t  cur;
	state_t  nxt;

	// Stage 1 moves forward when stage 2 is free or being drained
	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;

	// Capture the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.action       <= item.action;
			item_s1.reg_index    <= item.reg_index;
			item_s1.data_byte    <= item.data_byte;
			item_s1.clock_source <= item.clock_source;
			item_s1.blanked      <= item.blanked;
		end
	end

	// Counter state and its update
	pirqc_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cur    (cur),
		.nxt    (nxt)
	);

	// Result register: hold while stalled, load on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.irq_asserted    <= nxt.irq_line;
			res_s2.counter_value   <= nxt.main_count;
			res_s2.prescaler_value <= nxt.prescaler;
		end
	end

	assign result.valid           = valid_s2;
	assign result.irq_asserted    = res_s2.irq_asserted;
	assign result.counter_value   = res_s2.counter_value;
	assign result.prescaler_value = res_s2.prescaler_value;

	// State moves only when an item passes into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cur))
		else $error("counter state changed without an item");

	// A freshly loaded result matches the state it came from
	a_result_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2 && res_s2.counter_value == cur.main_count
			&& res_s2.prescaler_value == cur.prescaler && res_s2.irq_asserted == cur.irq_line)
		else $error("result does not match counter state");

endmodule

/* verif/tb_prescaled_irq_counter_core.sv */
module tb_prescaled_irq_counter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import pirqc_pkg::*;

	// Event sources as the mapper sees them
	typedef enum logic [1:0] {
		SRC_CPU_CYCLE  = 2'd0,
		SRC_SCANLINE   = 2'd1,
		SRC_VIDEO_READ = 2'd2,
		SRC_CPU_WRITE  = 2'd3
	} clock_src_e;

	localparam int RANDOM_ITEMS = 1600;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_MAX   = 10;

	// Mirror of the IRQ counter plus the queue of results it has promised.
	class irq_counter_board;
		state_t  mirror;
		result_t pending_results[$];
		int      mismatches;
		int      checked;

		function new();
			mirror = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		// Step the prescaler one tick; return 1 when its active bits wrap.
		function automatic bit tick_prescaler(bit up);
			logic [7:0] mask;
			logic [7:0] low;
			logic [7:0] nxt;
			bit         wrapped;
			mask = mirror.narrow_prescale ? NARROW_MASK : WIDE_MASK;
			low = mirror.prescaler & mask;
			wrapped = up ? (low == mask) : (low == 8'h00);
			nxt = up ? low + 8'd1 : low + mask;
			mirror.prescaler = (mirror.prescaler & ~mask) | (nxt & mask);
			return wrapped;
		endfunction

		function automatic void advance_counter(item_t it);
			bit up;
			bit hit_end;
			if (it.action == ACT_CLOCK) begin
				// Count only on the selected source with exactly one direction set.
				if (it.clock_source != mirror.source_mode) return;
				if (mirror.count_up == mirror.count_down) return;
				up = mirror.count_up;
				if (!tick_prescaler(up)) return;
				hit_end = up ? (mirror.main_count == 8'hff) : (mirror.main_count == 8'h00);
				mirror.main_count = up ? mirror.main_count + 8'd1 : mirror.main_count - 8'd1;
				if (hit_end && mirror.irq_enable && !it.blanked)
					mirror.irq_line = 1'b1;
				return;
			end
			case (it.reg_index)
				REG_ENABLE: begin
					mirror.irq_enable = it.data_byte[0];
					if (!it.data_byte[0])
						mirror.irq_line = 1'b0;
				end
				REG_CONTROL: begin
					mirror.source_mode = it.data_byte[1:0];
					mirror.narrow_prescale = it.data_byte[NARROW_BIT];
					mirror.count_down = it.data_byte[DOWN_BIT];
					mirror.count_up = it.data_byte[UP_BIT];
				end
				REG_DISABLE: begin
					mirror.irq_enable = 1'b0;
					mirror.irq_line = 1'b0;
				end
				REG_ENABLE_KP: mirror.irq_enable = 1'b1;
				REG_PRESCALER: mirror.prescaler = it.data_byte ^ mirror.flip_byte;
				REG_COUNT:     mirror.main_count = it.data_byte ^ mirror.flip_byte;
				REG_FLIP:      mirror.flip_byte = it.data_byte;
				default: ;
			endcase
		endfunction

		function automatic void note_transfer(item_t it);
			result_t r;
			advance_counter(it);
			r.irq_asserted = mirror.irq_line;
			r.counter_value = mirror.main_count;
			r.prescaler_value = mirror.prescaler;
			pending_results.push_back(r);
		endfunction

		function automatic void check_result(logic irq, logic [7:0] cnt, logic [7:0] presc);
			result_t want;
			checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d: none expected, got irq=%b count=%h presc=%h",
						checked, irq, cnt, presc);
				return;
			end
			want = pending_results.pop_front();
			if (irq !== want.irq_asserted || cnt !== want.counter_value
					|| presc !== want.prescaler_value) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d: expected irq=%b count=%h presc=%h, got irq=%b count=%h presc=%h",
						checked, want.irq_asserted, want.counter_value,
						want.prescaler_value, irq, cnt, presc);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pirqc_item_if   item_ch();
	pirqc_result_if result_ch();

	prescaled_irq_counter_core DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	irq_counter_board board;

	int         items_sent;
	int         burst_left;
	int         cycles;
	logic [7:0] flip_shadow;   // flip byte as last written, for loading exact values

	// Receiver stall pattern: a mode is held for a random stretch of cycles.
	int         stall_mode;
	int         stall_left;
	int         stall_tick;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Cycle guard: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: always ready, mostly ready, mostly stalled, or one beat in four.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 96);
		end else begin
			stall_left--;
		end
		stall_tick++;
		case (stall_mode)
			0: result_ch.ready <= 1'b1;
			1: result_ch.ready <= ($urandom_range(0, 3) != 0);
			2: result_ch.ready <= ($urandom_range(0, 3) == 0);
			default: result_ch.ready <= (stall_tick % 4 == 0);
		endcase
	end

	// Check every result transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			board.check_result(result_ch.irq_asserted, result_ch.counter_value,
				result_ch.prescaler_value);
	end

	// Drive one item and hold it until the transfer; the sender runs in bursts.
	task automatic send_item(input item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			// Mostly short bursts, sometimes a long unbroken stretch
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		@(negedge clk);
		item_ch.valid        <= 1'b1;
		item_ch.action       <= it.action;
		item_ch.reg_index    <= it.reg_index;
		item_ch.data_byte    <= it.data_byte;
		item_ch.clock_source <= it.clock_source;
		item_ch.blanked      <= it.blanked;
		do @(posedge clk); while (!item_ch.ready);
		board.note_transfer(it);
		if (it.action == ACT_WRITE && it.reg_index == REG_FLIP)
			flip_shadow = it.data_byte;
		items_sent++;
		burst_left--;
	endtask

	// Register write; the unused event fields carry random values.
	task automatic send_write(input logic [2:0] idx, input logic [7:0] data);
		item_t it;
		it.action = ACT_WRITE;
		it.reg_index = idx;
		it.data_byte = data;
		it.clock_source = 2'($urandom_range(0, 3));
		it.blanked = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	// Clock event; the unused write fields carry random values.
	task automatic send_event(input clock_src_e src, input logic blk);
		item_t it;
		it.action = ACT_CLOCK;
		it.reg_index = 3'($urandom_range(0, 7));
		it.data_byte = 8'($urandom_range(0, 255));
		it.clock_source = src;
		it.blanked = blk;
		send_item(it);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (board.pending_results.size() != 0) @(posedge clk);
	endtask

	// Control byte with the spare bits filled at random.
	function automatic logic [7:0] control_byte(clock_src_e src, bit narrow, bit up, bit down);
		logic [7:0] d;
		d = 8'($urandom_range(0, 255));
		d[1:0] = src;
		d[NARROW_BIT] = narrow;
		d[UP_BIT] = up;
		d[DOWN_BIT] = down;
		return d;
	endfunction

	// Random run: now and then unstructured items only; else configure, preload near a wrap, then feed clock events.
	task automatic run_scenario();
		clock_src_e src;
		bit         narrow;
		bit         up;
		bit         down;
		int         dir;
		int         run_len;
		logic [7:0] presc;
		logic [7:0] cnt;
		item_t      junk;
		// Now and then a burst of unstructured items
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(3, 12)) begin
				junk = item_t'(15'($urandom));
				send_item(junk);
			end
			return;
		end
		if ($urandom_range(0, 3) == 0)
			send_write(REG_FLIP, 8'($urandom_range(0, 255)));
		src = clock_src_e'($urandom_range(0, 3));
		narrow = ($urandom_range(0, 2) != 0);
		dir = $urandom_range(0, 9);
		up = 1'($urandom_range(0, 1));
		down = !up;
		if (dir == 0) begin
			up = 1'b1;
			down = 1'b1;
		end else if (dir == 1) begin
			up = 1'b0;
			down = 1'b0;
		end
		send_write(REG_CONTROL, control_byte(src, narrow, up, down));
		case ($urandom_range(0, 3))
			0: send_write(REG_ENABLE, 8'($urandom_range(0, 255)));
			1: send_write(REG_ENABLE_KP, 8'($urandom_range(0, 255)));
			2: send_write(REG_DISABLE, 8'($urandom_range(0, 255)));
			default: ;
		endcase
		// Park prescaler and count close to the edge they are heading for
		presc = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) < 7) begin
			if (narrow)
				presc[2:0] = up ? 3'(7 - $urandom_range(0, 2)) : 3'($urandom_range(0, 2));
			else
				presc = up ? 8'(255 - $urandom_range(0, 3)) : 8'($urandom_range(0, 3));
		end
		cnt = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) < 7)
			cnt = up ? 8'(255 - $urandom_range(0, 2)) : 8'($urandom_range(0, 2));
		send_write(REG_PRESCALER, presc ^ flip_shadow);
		send_write(REG_COUNT, cnt ^ flip_shadow);
		run_len = $urandom_range(4, 40);
		repeat (run_len) begin
			if ($urandom_range(0, 19) == 0)
				send_write(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			else if ($urandom_range(0, 19) < 17)
				send_event(src, $urandom_range(0, 4) == 0);
			else
				send_event(clock_src_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int scenario;
		board = new();
		items_sent = 0;
		burst_left = 0;
		cycles = 0;
		flip_shadow = 8'h00;
		stall_mode = 0;
		stall_left = 0;
		stall_tick = 0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_WRITE;
		item_ch.reg_index = REG_NONE;
		item_ch.data_byte = 8'h00;
		item_ch.clock_source = SRC_CPU_CYCLE;
		item_ch.blanked = 1'b0;
		result_ch.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Register seven is accepted and changes nothing
		send_write(REG_NONE, 8'hff);
		// Wide prescaler counting up: wrap both stages and raise the line
		send_write(REG_ENABLE, 8'h01);
		send_write(REG_CONTROL, control_byte(SRC_CPU_CYCLE, 1'b0, 1'b1, 1'b0));
		send_write(REG_PRESCALER, 8'hff);
		send_write(REG_COUNT, 8'hff);
		send_event(SRC_CPU_CYCLE, 1'b0);
		// Wrong source: nothing moves
		send_event(SRC_SCANLINE, 1'b0);
		// Enable bit clear drops the line; register three re-enables only
		send_write(REG_ENABLE, 8'h00);
		send_write(REG_ENABLE_KP, 8'h00);
		// Narrow prescaler counting down through the flip byte
		send_write(REG_FLIP, 8'ha5);
		send_write(REG_CONTROL, control_byte(SRC_SCANLINE, 1'b1, 1'b0, 1'b1));
		send_write(REG_PRESCALER, 8'ha5 ^ 8'hf8);
		send_write(REG_COUNT, 8'ha5);
		// Blanked wrap must not raise the line
		send_event(SRC_SCANLINE, 1'b1);
		send_write(REG_COUNT, 8'ha5);
		send_write(REG_PRESCALER, 8'ha5 ^ 8'h30);
		send_event(SRC_SCANLINE, 1'b0);
		send_write(REG_DISABLE, 8'h00);
		// Both directions, then neither: events are ignored
		send_write(REG_CONTROL, control_byte(SRC_SCANLINE, 1'b1, 1'b1, 1'b1));
		send_event(SRC_SCANLINE, 1'b0);
		send_write(REG_CONTROL, control_byte(SRC_SCANLINE, 1'b1, 1'b0, 1'b0));
		send_event(SRC_SCANLINE, 1'b0);
		// Wrap with interrupts disabled leaves the line low
		send_write(REG_FLIP, 8'h00);
		send_write(REG_COUNT, 8'h00);
		send_write(REG_PRESCALER, 8'h00);
		send_write(REG_CONTROL, control_byte(SRC_VIDEO_READ, 1'b0, 1'b0, 1'b1));
		send_event(SRC_VIDEO_READ, 1'b0);
		send_event(SRC_CPU_WRITE, 1'b1);

		wait_drained();

		scenario = 0;
		while (items_sent < RANDOM_ITEMS + 28) begin
			run_scenario();
			scenario++;
			if (scenario % 20 == 0)
				wait_drained();
		end

		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
